FILE: rtl/core/swv_pkg.sv
`default_nettype none
package swv_pkg;

    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 200;
    localparam int CORDIC_STAGES = 16;

    // cordic datapath widths
    localparam int CW = 40;
    localparam int ZW = 32;

    localparam logic signed [ZW-1:0] ANG_PI      = 32'sd205887;
    localparam logic signed [ZW-1:0] ANG_HALF_PI = 32'sd102944;
    localparam logic signed [ZW-1:0] ANG_TWO_PI  = 32'sd411775;
    localparam logic signed [17:0]   INV_GAIN    = 18'sd39797;
    // ceil(2^40 / two pi) for the modulo quotient estimate
    localparam logic signed [23:0]   RECIP_TWO_PI = 24'sd2670176;
    localparam int RECIP_SHIFT = 40;

    localparam logic REG_RADIUS_OFFSET = 1'b0;
    localparam logic REG_TWIST_RATE    = 1'b1;

    typedef struct packed {
        logic valid;
        logic en;
    } pipe_ctl_t;

    function automatic logic signed [ZW-1:0] atan_q16(input int i);
        logic signed [ZW-1:0] r;
        r = '0;
        case (i)
            0:  r = 32'sd51472;
            1:  r = 32'sd30386;
            2:  r = 32'sd16055;
            3:  r = 32'sd8150;
            4:  r = 32'sd4091;
            5:  r = 32'sd2047;
            6:  r = 32'sd1024;
            7:  r = 32'sd512;
            8:  r = 32'sd256;
            9:  r = 32'sd128;
            10: r = 32'sd64;
            11: r = 32'sd32;
            12: r = 32'sd16;
            13: r = 32'sd8;
            14: r = 32'sd4;
            15: r = 32'sd2;
            16: r = 32'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/swv_vec.sv
`default_nettype none
module swv_vec #(
    parameter int SCREEN_WIDTH  = swv_pkg::SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = swv_pkg::SCREEN_HEIGHT,
    parameter int CORDIC_STAGES = swv_pkg::CORDIC_STAGES
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire swv_pkg::pipe_ctl_t               ctl_in,
    input  wire logic [8:0]                       pix_x,
    input  wire logic [7:0]                       pix_y,
    output logic                                  valid_out,
    output logic signed [swv_pkg::CW-1:0]         x_out,
    output logic signed [swv_pkg::ZW-1:0]         z_out,
    output logic                                  center_out
);
    localparam int CW = swv_pkg::CW;
    localparam int ZW = swv_pkg::ZW;
    localparam logic signed [CW-1:0] CX = CW'(SCREEN_WIDTH * 32768);
    localparam logic signed [CW-1:0] CY = CW'(SCREEN_HEIGHT * 32768);

    logic                 v_reg [0:CORDIC_STAGES];
    logic signed [CW-1:0] x_reg [0:CORDIC_STAGES];
    logic signed [CW-1:0] y_reg [0:CORDIC_STAGES];
    logic signed [ZW-1:0] z_reg [0:CORDIC_STAGES];
    logic                 c_reg [0:CORDIC_STAGES];

    logic signed [CW-1:0] dx, dy;
    logic signed [CW-1:0] x_next, y_next;
    logic signed [ZW-1:0] z_next;

    always_comb begin
        dx = $signed({{(CW-25){1'b0}}, pix_x, 16'b0}) - CX;
        dy = $signed({{(CW-24){1'b0}}, pix_y, 16'b0}) - CY;
        x_next = dx;
        y_next = dy;
        z_next = '0;
        // fold the left half plane onto the right one
        if (dx < 0) begin
            x_next = -dx;
            y_next = -dy;
            z_next = (dy >= 0) ? swv_pkg::ANG_PI : -swv_pkg::ANG_PI;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (ctl_in.en) begin
            v_reg[0] <= ctl_in.valid;
        end
        if (ctl_in.en) begin
            x_reg[0] <= x_next;
            y_reg[0] <= y_next;
            z_reg[0] <= z_next;
            c_reg[0] <= (dx == 0) && (dy == 0);
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
        localparam logic signed [ZW-1:0] AT = swv_pkg::atan_q16(i);
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i+1] <= 1'b0;
            end else if (ctl_in.en) begin
                v_reg[i+1] <= v_reg[i];
            end
            if (ctl_in.en) begin
                c_reg[i+1] <= c_reg[i];
                if (y_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + AT;
                end else begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - AT;
                end
            end
        end
    end

    assign valid_out  = v_reg[CORDIC_STAGES];
    assign x_out      = x_reg[CORDIC_STAGES];
    assign z_out      = z_reg[CORDIC_STAGES];
    assign center_out = c_reg[CORDIC_STAGES];

    // y of the last stage is not needed
    logic unused_y;
    assign unused_y = ^y_reg[CORDIC_STAGES];
endmodule
`default_nettype wire

FILE: rtl/core/swv_angle.sv
`default_nettype none
module swv_angle (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire swv_pkg::pipe_ctl_t               ctl_in,
    input  wire logic signed [swv_pkg::CW-1:0]    x_in,
    input  wire logic signed [swv_pkg::ZW-1:0]    z_in,
    input  wire logic                             center_in,
    input  wire logic signed [15:0]               radius_offset,
    input  wire logic signed [23:0]               twist_rate,
    output logic                                  valid_out,
    output logic signed [swv_pkg::CW-1:0]         x0_out,
    output logic signed [swv_pkg::ZW-1:0]         ang_out,
    output logic                                  flip_out
);
    localparam int CW = swv_pkg::CW;
    localparam int ZW = swv_pkg::ZW;

    logic [6:0] v_reg;

    logic signed [49:0]   pd_reg;
    logic signed [ZW-1:0] z1_reg, z2_reg, z3_reg;
    logic                 c1_reg;
    logic signed [23:0]   rad2_reg;
    logic signed [47:0]   pt3_reg;
    logic signed [42:0]   pg3_reg;
    logic signed [ZW-1:0] ang4_reg, ang5_reg;
    logic signed [CW-1:0] x04_reg, x05_reg, x06_reg, x07_reg;
    logic signed [55:0]   qp5_reg;
    logic signed [ZW-1:0] r6_reg, ang7_reg;
    logic                 flip7_reg;

    logic signed [49:0]   pd_round;
    logic signed [23:0]   rad_next;
    logic signed [47:0]   pt_round;
    logic signed [ZW-1:0] ang_next;
    logic signed [42:0]   pg_round;
    logic signed [15:0]   q;
    logic signed [36:0]   qt;
    logic signed [ZW-1:0] r_fix, r_fold, ang_fold;
    logic                 flip_next;

    always_comb begin
        pd_round = pd_reg + 50'sd8388608;
        rad_next = 24'(radius_offset) + (c1_reg ? 24'sd0 : 24'(pd_round >>> 24));
        pt_round = pt3_reg + 48'sd32768;
        ang_next = z3_reg + ZW'(pt_round >>> 16);
        pg_round = pg3_reg + 43'sd128;
        q        = 16'(qp5_reg >>> swv_pkg::RECIP_SHIFT);
        qt       = 37'(q) * 37'(swv_pkg::ANG_TWO_PI);
        // floor modulo two pi, estimate is off by at most one
        r_fix = r6_reg;
        if (r6_reg < 0) begin
            r_fix = r6_reg + swv_pkg::ANG_TWO_PI;
        end else if (r6_reg >= swv_pkg::ANG_TWO_PI) begin
            r_fix = r6_reg - swv_pkg::ANG_TWO_PI;
        end
        r_fold = (r_fix > swv_pkg::ANG_PI) ? r_fix - swv_pkg::ANG_TWO_PI : r_fix;
        ang_fold  = r_fold;
        flip_next = 1'b0;
        if (r_fold > swv_pkg::ANG_HALF_PI) begin
            ang_fold  = r_fold - swv_pkg::ANG_PI;
            flip_next = 1'b1;
        end else if (r_fold < -swv_pkg::ANG_HALF_PI) begin
            ang_fold  = r_fold + swv_pkg::ANG_PI;
            flip_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (ctl_in.en) begin
            v_reg <= {v_reg[5:0], ctl_in.valid};
        end
        if (ctl_in.en) begin
            pd_reg    <= 50'(x_in[31:0]) * 50'(swv_pkg::INV_GAIN);
            z1_reg    <= z_in;
            c1_reg    <= center_in;
            rad2_reg  <= rad_next;
            z2_reg    <= c1_reg ? '0 : z1_reg;
            pt3_reg   <= 48'(rad2_reg) * 48'(twist_rate);
            pg3_reg   <= 43'(rad2_reg) * 43'(swv_pkg::INV_GAIN);
            z3_reg    <= z2_reg;
            ang4_reg  <= ang_next;
            x04_reg   <= CW'(pg_round >>> 8);
            qp5_reg   <= 56'(ang4_reg) * 56'(swv_pkg::RECIP_TWO_PI);
            ang5_reg  <= ang4_reg;
            x05_reg   <= x04_reg;
            r6_reg    <= ang5_reg - ZW'(qt);
            x06_reg   <= x05_reg;
            ang7_reg  <= ang_fold;
            flip7_reg <= flip_next;
            x07_reg   <= x06_reg;
        end
    end

    logic unused_x;
    assign unused_x = ^x_in[CW-1:32];

    assign valid_out = v_reg[6];
    assign x0_out    = x07_reg;
    assign ang_out   = ang7_reg;
    assign flip_out  = flip7_reg;
endmodule
`default_nettype wire

FILE: rtl/core/swv_rot.sv
`default_nettype none
module swv_rot #(
    parameter int CORDIC_STAGES = swv_pkg::CORDIC_STAGES
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire swv_pkg::pipe_ctl_t               ctl_in,
    input  wire logic signed [swv_pkg::CW-1:0]    x0_in,
    input  wire logic signed [swv_pkg::ZW-1:0]    ang_in,
    input  wire logic                             flip_in,
    output logic                                  valid_out,
    output logic signed [swv_pkg::CW-1:0]         x_out,
    output logic signed [swv_pkg::CW-1:0]         y_out,
    output logic                                  flip_out
);
    localparam int CW = swv_pkg::CW;
    localparam int ZW = swv_pkg::ZW;

    logic                 v_reg [0:CORDIC_STAGES];
    logic signed [CW-1:0] x_reg [0:CORDIC_STAGES];
    logic signed [CW-1:0] y_reg [0:CORDIC_STAGES];
    logic signed [ZW-1:0] z_reg [0:CORDIC_STAGES];
    logic                 f_reg [0:CORDIC_STAGES];

    always_comb begin
        v_reg[0] = ctl_in.valid;
        x_reg[0] = x0_in;
        y_reg[0] = '0;
        z_reg[0] = ang_in;
        f_reg[0] = flip_in;
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
        localparam logic signed [ZW-1:0] AT = swv_pkg::atan_q16(i);
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i+1] <= 1'b0;
            end else if (ctl_in.en) begin
                v_reg[i+1] <= v_reg[i];
            end
            if (ctl_in.en) begin
                f_reg[i+1] <= f_reg[i];
                if (z_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - AT;
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + AT;
                end
            end
        end
    end

    logic unused_z;
    assign unused_z = ^z_reg[CORDIC_STAGES];

    assign valid_out = v_reg[CORDIC_STAGES];
    assign x_out     = x_reg[CORDIC_STAGES];
    assign y_out     = y_reg[CORDIC_STAGES];
    assign flip_out  = f_reg[CORDIC_STAGES];
endmodule
`default_nettype wire

FILE: rtl/core/swv_out.sv
`default_nettype none
module swv_out #(
    parameter int SCREEN_WIDTH  = swv_pkg::SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = swv_pkg::SCREEN_HEIGHT
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire swv_pkg::pipe_ctl_t               ctl_in,
    input  wire logic signed [swv_pkg::CW-1:0]    x_in,
    input  wire logic signed [swv_pkg::CW-1:0]    y_in,
    input  wire logic                             flip_in,
    output logic                                  valid_out,
    output logic [15:0]                           source_offset,
    output logic                                  off_screen
);
    localparam int CW = swv_pkg::CW;
    localparam logic signed [CW-1:0] CX = CW'(SCREEN_WIDTH * 32768);
    localparam logic signed [CW-1:0] CY = CW'(SCREEN_HEIGHT * 32768);
    localparam logic [15:0] MARKER = 16'((SCREEN_WIDTH * SCREEN_HEIGHT) % 65536);
    localparam logic signed [24:0] MAX_X = 25'(SCREEN_WIDTH - 1);
    localparam logic signed [24:0] MAX_Y = 25'(SCREEN_HEIGHT - 1);

    logic [1:0]         v_reg;
    logic signed [24:0] nx_reg, ny_reg;
    logic [15:0]        offset_reg;
    logic               off_reg;

    logic signed [CW-1:0] px, py, pxa, pya;
    logic signed [24:0]   nx_next, ny_next;
    logic                 off_next;
    logic [31:0]          lin;

    always_comb begin
        px = flip_in ? CX - x_in : CX + x_in;
        py = flip_in ? CY - y_in : CY + y_in;
        // truncate toward zero
        pxa = (px < 0) ? -px : px;
        pya = (py < 0) ? -py : py;
        nx_next = (px < 0) ? -25'(pxa >>> 16) : 25'(pxa >>> 16);
        ny_next = (py < 0) ? -25'(pya >>> 16) : 25'(pya >>> 16);
        off_next = (nx_reg < 0) || (nx_reg > MAX_X) || (ny_reg < 0) || (ny_reg > MAX_Y);
        lin = 32'(nx_reg) + 32'(ny_reg) * 32'(SCREEN_WIDTH);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (ctl_in.en) begin
            v_reg <= {v_reg[0], ctl_in.valid};
        end
        if (ctl_in.en) begin
            nx_reg     <= nx_next;
            ny_reg     <= ny_next;
            offset_reg <= off_next ? MARKER : lin[15:0];
            off_reg    <= off_next;
        end
    end

    assign valid_out     = v_reg[1];
    assign source_offset = offset_reg;
    assign off_screen    = off_reg;
endmodule
`default_nettype wire

FILE: rtl/core/swirl_warp_source_offset.sv
`default_nettype none
// Swirl warp source offset: for each destination pixel (s_pix_x, s_pix_y) gives the linear
// offset of the source pixel of a swirl around the screen center, or W*H mod 65536 with
// m_off_screen set when the warped point falls outside. One pixel is taken per cycle
// unless a result waits at the output, in which case the whole pipeline holds. The pipeline
// is made of the vectoring CORDIC, seven angle stages with the twist multiply and modulo two
// pi reduction, the rotating CORDIC and two output stages. Register 0 is radius_offset (Q8.8),
// register 1 is twist_rate (Q0.24); write them only while the pipeline is empty.
module swirl_warp_source_offset #(
    parameter int SCREEN_WIDTH  = swv_pkg::SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = swv_pkg::SCREEN_HEIGHT,
    parameter int CORDIC_STAGES = swv_pkg::CORDIC_STAGES
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [8:0]  s_pix_x,
    input  wire logic [7:0]  s_pix_y,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_source_offset,
    output logic             m_off_screen,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [23:0] cfg_wdata
);
    localparam int CW = swv_pkg::CW;
    localparam int ZW = swv_pkg::ZW;

    logic signed [15:0] radius_offset_reg;
    logic signed [23:0] twist_rate_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_offset_reg <= 16'sd384;
            twist_rate_reg    <= 24'sd41943;
        end else if (cfg_we) begin
            case (cfg_index)
                swv_pkg::REG_RADIUS_OFFSET: radius_offset_reg <= cfg_wdata[15:0];
                swv_pkg::REG_TWIST_RATE:    twist_rate_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    logic                 v_vec, c_vec, v_ang, f_ang, v_rot, f_rot;
    logic signed [CW-1:0] x_vec, x0_ang, x_rot, y_rot;
    logic signed [ZW-1:0] z_vec, a_ang;

    swv_vec #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .SCREEN_HEIGHT(SCREEN_HEIGHT),
        .CORDIC_STAGES(CORDIC_STAGES)
    ) u_vec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl_in    ('{valid: s_valid, en: en}),
        .pix_x     (s_pix_x),
        .pix_y     (s_pix_y),
        .valid_out (v_vec),
        .x_out     (x_vec),
        .z_out     (z_vec),
        .center_out(c_vec)
    );

    swv_angle u_angle (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctl_in       ('{valid: v_vec, en: en}),
        .x_in         (x_vec),
        .z_in         (z_vec),
        .center_in    (c_vec),
        .radius_offset(radius_offset_reg),
        .twist_rate   (twist_rate_reg),
        .valid_out    (v_ang),
        .x0_out       (x0_ang),
        .ang_out      (a_ang),
        .flip_out     (f_ang)
    );

    swv_rot #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) u_rot (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl_in   ('{valid: v_ang, en: en}),
        .x0_in    (x0_ang),
        .ang_in   (a_ang),
        .flip_in  (f_ang),
        .valid_out(v_rot),
        .x_out    (x_rot),
        .y_out    (y_rot),
        .flip_out (f_rot)
    );

    swv_out #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .SCREEN_HEIGHT(SCREEN_HEIGHT)
    ) u_out (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctl_in       ('{valid: v_rot, en: en}),
        .x_in         (x_rot),
        .y_in         (y_rot),
        .flip_in      (f_rot),
        .valid_out    (m_valid),
        .source_offset(m_source_offset),
        .off_screen   (m_off_screen)
    );
endmodule
`default_nettype wire

FILE: rtl/core/swv_checker.sv
`default_nettype none
module swv_checker #(
    parameter int SCREEN_WIDTH  = swv_pkg::SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = swv_pkg::SCREEN_HEIGHT
) (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [15:0] m_source_offset,
    input wire logic        m_off_screen
);
    localparam int AREA = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam logic [15:0] MARKER = 16'(AREA % 65536);
    localparam logic BIG = AREA > 65535;

    // a stalled transfer keeps its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_source_offset) && $stable(m_off_screen))
        else $error("stalled result changed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_off_screen |-> m_source_offset == MARKER)
        else $error("off screen result without marker");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_off_screen |-> BIG || (32'(m_source_offset) < 32'(AREA)))
        else $error("on screen offset beyond the screen");

    // pipeline is flushed by reset
    assert property (@(posedge aclk) $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");
endmodule

bind swirl_warp_source_offset swv_checker #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
) u_swv_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_source_offset(m_source_offset),
    .m_off_screen   (m_off_screen)
);
`default_nettype wire
